// ----- hw/rtl/tcpq_pkg.sv -----
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared types and codes for the three-class priority queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

   localparam int NUM_CLASSES = 3;

   // operation codes
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // class codes
   localparam logic [1:0] CLS_REGULAR  = 2'd0;
   localparam logic [1:0] CLS_POOR     = 2'd1;
   localparam logic [1:0] CLS_CRITICAL = 2'd2;

   // result status codes
   localparam logic [1:0] ST_ENQUEUED = 2'd0;
   localparam logic [1:0] ST_DEQUEUED = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   // entry layout below the tag: {gender, age}
   localparam int AGE_BITS = 7;
   localparam int LOW_BITS = AGE_BITS + 1;

   // decision made by the pointer control for one transaction
   typedef struct packed {
      logic       wr_en;
      logic       rd_en;
      logic [1:0] status;
      logic [1:0] cls;
   } decision_type;

endpackage

// ----- hw/rtl/tcpq_store.sv -----
// ----------------------------------------------------------------------------
// tcpq_store
// Entry memory: one port, write or registered read.
// ----------------------------------------------------------------------------
module tcpq_store #(
   parameter int DEPTH = 192,
   parameter int WIDTH = 24
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/tcpq_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcpq_ctrl
// Per-class ring pointers and counts; picks the class and memory address
// for each transaction and updates the ring state.
// ----------------------------------------------------------------------------
module tcpq_ctrl
   import tcpq_pkg::*;
#(
   parameter int CLASS_DEPTH = 64
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         accept,
   input  logic                                         operation,
   input  logic [1:0]                                   in_class,
   output decision_type                                 decision,
   output logic [$clog2(NUM_CLASSES*CLASS_DEPTH)-1:0]   addr
);

   localparam int IDX_W  = $clog2(CLASS_DEPTH);
   localparam int CNT_W  = $clog2(CLASS_DEPTH + 1);
   localparam int ADDR_W = $clog2(NUM_CLASSES * CLASS_DEPTH);

   logic [IDX_W-1:0] head_ff  [NUM_CLASSES];
   logic [IDX_W-1:0] head_in  [NUM_CLASSES];
   logic [IDX_W-1:0] tail_ff  [NUM_CLASSES];
   logic [IDX_W-1:0] tail_in  [NUM_CLASSES];
   logic [CNT_W-1:0] count_ff [NUM_CLASSES];
   logic [CNT_W-1:0] count_in [NUM_CLASSES];

   logic [CNT_W-1:0] enq_count;
   logic [IDX_W-1:0] enq_tail;
   logic [IDX_W-1:0] deq_head;
   logic [1:0]       deq_cls;
   logic             nonempty;
   logic             enq_ok;
   logic             do_wr;
   logic             do_rd;
   logic [1:0]       act_cls;
   logic [IDX_W-1:0] act_slot;
   logic [ADDR_W-1:0] base;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] slot);
      ring_next = (slot == IDX_W'(CLASS_DEPTH - 1)) ? '0 : slot + 1'b1;
   endfunction

   // lookups for the enqueue class; the invalid class code reads as full
   always_comb begin
      case (in_class)
         CLS_REGULAR: begin
            enq_count = count_ff[0];
            enq_tail  = tail_ff[0];
         end
         CLS_POOR: begin
            enq_count = count_ff[1];
            enq_tail  = tail_ff[1];
         end
         CLS_CRITICAL: begin
            enq_count = count_ff[2];
            enq_tail  = tail_ff[2];
         end
         default: begin
            enq_count = CNT_W'(CLASS_DEPTH);
            enq_tail  = '0;
         end
      endcase
   end

   // strict priority: critical, then poor, then regular
   always_comb begin
      nonempty = 1'b1;
      if (count_ff[2] != '0) begin
         deq_cls  = CLS_CRITICAL;
         deq_head = head_ff[2];
      end else if (count_ff[1] != '0) begin
         deq_cls  = CLS_POOR;
         deq_head = head_ff[1];
      end else begin
         deq_cls  = CLS_REGULAR;
         deq_head = head_ff[0];
         nonempty = (count_ff[0] != '0);
      end
   end

   assign enq_ok   = (enq_count != CNT_W'(CLASS_DEPTH));
   assign do_wr    = accept && (operation == OP_ENQUEUE) && enq_ok;
   assign do_rd    = accept && (operation == OP_DEQUEUE) && nonempty;
   assign act_cls  = (operation == OP_ENQUEUE) ? in_class : deq_cls;
   assign act_slot = (operation == OP_ENQUEUE) ? enq_tail : deq_head;

   always_comb begin
      case (act_cls)
         CLS_POOR:     base = ADDR_W'(CLASS_DEPTH);
         CLS_CRITICAL: base = ADDR_W'(2 * CLASS_DEPTH);
         default:      base = '0;
      endcase
   end

   assign addr = base + ADDR_W'(act_slot);

   always_comb begin
      decision.wr_en = do_wr;
      decision.rd_en = do_rd;
      if (operation == OP_ENQUEUE) begin
         decision.status = enq_ok ? ST_ENQUEUED : ST_FULL;
         decision.cls    = CLS_REGULAR;
      end else begin
         decision.status = nonempty ? ST_DEQUEUED : ST_EMPTY;
         decision.cls    = nonempty ? deq_cls : CLS_REGULAR;
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
         head_in[c]  = head_ff[c];
         tail_in[c]  = tail_ff[c];
         count_in[c] = count_ff[c];
         if (do_wr && (in_class == 2'(c))) begin
            tail_in[c]  = ring_next(tail_ff[c]);
            count_in[c] = count_ff[c] + 1'b1;
         end
         if (do_rd && (deq_cls == 2'(c))) begin
            head_in[c]  = ring_next(head_ff[c]);
            count_in[c] = count_ff[c] - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            head_ff[c]  <= '0;
            tail_ff[c]  <= '0;
            count_ff[c] <= '0;
         end
      end else begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            head_ff[c]  <= head_in[c];
            tail_ff[c]  <= tail_in[c];
            count_ff[c] <= count_in[c];
         end
      end
   end

endmodule

// ----- hw/rtl/three_class_priority_queue.sv -----
// ----------------------------------------------------------------------------
// three_class_priority_queue
// Strict priority queue with three classes, FIFO within each class.
// ----------------------------------------------------------------------------
// In the cycle of acceptance a transaction updates the class ring pointers and
// addresses the entry memory; in the next cycle the memory's registered read
// data goes to the output register, or to the skid stage while the output is
// stalled. No new transaction is accepted while one is in its memory read
// cycle or held in the skid stage, since the entry memory has a single port.
// Results leave through an output register backed by a one-entry skid stage,
// so a new transaction is taken while an earlier result still waits on rsp_ready.
// Classes: 2 critical, 1 poor, 0 regular; a dequeue takes a critical record
// before any poor record, and a poor record before any regular record.
module three_class_priority_queue
   import tcpq_pkg::*;
#(
   parameter int CLASS_DEPTH = 64,
   parameter int TAG_BITS    = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_operation,
   input  logic [1:0]          req_in_class,
   input  logic [AGE_BITS-1:0] req_in_age,
   input  logic                req_in_gender,
   input  logic [TAG_BITS-1:0] req_in_tag,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic [1:0]          rsp_out_class,
   output logic [AGE_BITS-1:0] rsp_out_age,
   output logic                rsp_out_gender,
   output logic [TAG_BITS-1:0] rsp_out_tag
);

   localparam int DEPTH   = NUM_CLASSES * CLASS_DEPTH;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int ENTRY_W = TAG_BITS + LOW_BITS;

   logic                accept;
   decision_type        decision;
   logic [ADDR_W-1:0]   addr;
   logic [ENTRY_W-1:0]  wr_data;
   logic [ENTRY_W-1:0]  rd_data;

   // transaction in its memory read cycle
   logic                a_valid_ff;
   logic [1:0]          a_status_ff;
   logic [1:0]          a_class_ff;
   logic [1:0]          a_class;
   logic [AGE_BITS-1:0] a_age;
   logic                a_gender;
   logic [TAG_BITS-1:0] a_tag;

   // skid stage
   logic                b_valid_ff;
   logic [1:0]          b_status_ff;
   logic [1:0]          b_class_ff;
   logic [AGE_BITS-1:0] b_age_ff;
   logic                b_gender_ff;
   logic [TAG_BITS-1:0] b_tag_ff;

   // output register
   logic                rsp_valid_ff;
   logic [1:0]          rsp_status_ff;
   logic [1:0]          rsp_class_ff;
   logic [AGE_BITS-1:0] rsp_age_ff;
   logic                rsp_gender_ff;
   logic [TAG_BITS-1:0] rsp_tag_ff;

   logic                out_free;

   assign req_ready = !a_valid_ff && !b_valid_ff;
   assign accept    = req_valid && req_ready;
   assign wr_data   = {req_in_tag, req_in_gender, req_in_age};

   tcpq_ctrl #(
      .CLASS_DEPTH (CLASS_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .operation (req_operation),
      .in_class  (req_in_class),
      .decision  (decision),
      .addr      (addr)
   );

   tcpq_store #(
      .DEPTH (DEPTH),
      .WIDTH (ENTRY_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (decision.wr_en),
      .rd_en   (decision.rd_en),
      .addr    (addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
      end
      if (accept) begin
         a_status_ff <= decision.status;
         a_class_ff  <= decision.cls;
      end
   end

   // only a dequeue carries record fields
   always_comb begin
      if (a_status_ff == ST_DEQUEUED) begin
         a_class  = a_class_ff;
         a_age    = rd_data[AGE_BITS-1:0];
         a_gender = rd_data[AGE_BITS];
         a_tag    = rd_data[ENTRY_W-1:LOW_BITS];
      end else begin
         a_class  = CLS_REGULAR;
         a_age    = '0;
         a_gender = 1'b0;
         a_tag    = '0;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // a and b are never both valid: b only fills from a, and nothing is
   // accepted while b holds a result
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (b_valid_ff && out_free) begin
            b_valid_ff   <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (a_valid_ff && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (a_valid_ff) begin
            b_valid_ff <= 1'b1;
         end else if (out_free) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (b_valid_ff && out_free) begin
         rsp_status_ff <= b_status_ff;
         rsp_class_ff  <= b_class_ff;
         rsp_age_ff    <= b_age_ff;
         rsp_gender_ff <= b_gender_ff;
         rsp_tag_ff    <= b_tag_ff;
      end else if (a_valid_ff && out_free) begin
         rsp_status_ff <= a_status_ff;
         rsp_class_ff  <= a_class;
         rsp_age_ff    <= a_age;
         rsp_gender_ff <= a_gender;
         rsp_tag_ff    <= a_tag;
      end
      if (a_valid_ff && !out_free) begin
         b_status_ff <= a_status_ff;
         b_class_ff  <= a_class;
         b_age_ff    <= a_age;
         b_gender_ff <= a_gender;
         b_tag_ff    <= a_tag;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_class  = rsp_class_ff;
   assign rsp_out_age    = rsp_age_ff;
   assign rsp_out_gender = rsp_gender_ff;
   assign rsp_out_tag    = rsp_tag_ff;

   a_skid_exclusive: assert property (
      @(posedge clock) disable iff (reset) !(a_valid_ff && b_valid_ff))
      else $error("read stage and skid stage both hold a transaction");

   a_no_loss: assert property (
      @(posedge clock) disable iff (reset)
      (a_valid_ff && !out_free) |=> (b_valid_ff && rsp_valid_ff))
      else $error("result dropped while output stalled");

   a_dequeue_class: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_DEQUEUED)) |-> (rsp_class_ff <= CLS_CRITICAL))
      else $error("dequeued record carries an invalid class");

   a_idle_fields_zero: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_DEQUEUED)) |->
         (rsp_class_ff == CLS_REGULAR && rsp_age_ff == '0 &&
          !rsp_gender_ff && rsp_tag_ff == '0))
      else $error("non-dequeue result carries record fields");

endmodule

// ----- verif/three_class_priority_queue_tb.sv -----
// ----------------------------------------------------------------------------
// three_class_priority_queue_tb
// Self-checking bench for the three-class strict priority queue. Requests
// come from a backlog filled up front; a clocked driver presents them with
// random gaps, and a clocked monitor predicts every result from its own copy
// of the class rings and checks each returned transaction field by field.
// ----------------------------------------------------------------------------
module three_class_priority_queue_tb
   import tcpq_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLASS_DEPTH    = 64;
   localparam int TAG_BITS       = 16;
   localparam int RANDOM_ITEMS   = 1350;
   localparam int IDLE_PCT       = 29;
   localparam int STEADY_FROM    = 600;
   localparam int STEADY_TO      = 900;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 12;
   localparam int MAX_PRINTED    = 40;

   // class code outside the three defined classes
   localparam logic [1:0] CLS_INVALID = 2'd3;

   typedef struct packed {
      logic                operation;
      logic [1:0]          cls;
      logic [AGE_BITS-1:0] age;
      logic                gender;
      logic [TAG_BITS-1:0] tag;
   } request_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [1:0]          cls;
      logic [AGE_BITS-1:0] age;
      logic                gender;
      logic [TAG_BITS-1:0] tag;
   } outcome_type;

   typedef enum {SEG_MIXED, SEG_ENQ_HEAVY, SEG_FILL, SEG_DRAIN} segment_kind_type;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_ready;
   logic                req_operation  = OP_ENQUEUE;
   logic [1:0]          req_in_class   = CLS_REGULAR;
   logic [AGE_BITS-1:0] req_in_age     = '0;
   logic                req_in_gender  = 1'b0;
   logic [TAG_BITS-1:0] req_in_tag     = '0;
   logic                rsp_valid;
   logic                rsp_ready      = 1'b0;
   logic [1:0]          rsp_status;
   logic [1:0]          rsp_out_class;
   logic [AGE_BITS-1:0] rsp_out_age;
   logic                rsp_out_gender;
   logic [TAG_BITS-1:0] rsp_out_tag;

   request_type request_backlog[$];
   outcome_type awaited_results[$];

   // predictor state: one FIFO ring per class
   request_type ring_entry [NUM_CLASSES][CLASS_DEPTH];
   int          ring_head  [NUM_CLASSES];
   int          ring_tail  [NUM_CLASSES];
   int          ring_fill  [NUM_CLASSES];

   int   error_count       = 0;
   int   accepted_requests = 0;
   int   checked_results   = 0;
   int   stalled_cycles    = 0;
   int   status_tally[4];
   bit   req_taken         = 1'b0;
   logic steady;

   assign steady = (accepted_requests >= STEADY_FROM) && (accepted_requests < STEADY_TO);

   three_class_priority_queue #(
      .CLASS_DEPTH(CLASS_DEPTH),
      .TAG_BITS   (TAG_BITS)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_in_class  (req_in_class),
      .req_in_age    (req_in_age),
      .req_in_gender (req_in_gender),
      .req_in_tag    (req_in_tag),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_out_class (rsp_out_class),
      .rsp_out_age   (rsp_out_age),
      .rsp_out_gender(rsp_out_gender),
      .rsp_out_tag   (rsp_out_tag)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTED) begin
         $display("ERROR at %0t ns: %s", $time, msg);
      end
      error_count++;
   endtask

   // Strict priority: critical, then poor, then regular; FIFO inside a class.
   function automatic outcome_type predict_outcome(input request_type r);
      outcome_type o;
      int          c;
      bit          found;
      o     = '0;
      found = 1'b0;
      if (r.operation == OP_ENQUEUE) begin
         if (int'(r.cls) >= NUM_CLASSES) begin
            o.status = ST_FULL;
         end else if (ring_fill[r.cls] == CLASS_DEPTH) begin
            o.status = ST_FULL;
         end else begin
            ring_entry[r.cls][ring_tail[r.cls]] = r;
            ring_tail[r.cls] = (ring_tail[r.cls] + 1) % CLASS_DEPTH;
            ring_fill[r.cls]++;
            o.status = ST_ENQUEUED;
         end
      end else begin
         o.status = ST_EMPTY;
         for (c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (!found && ring_fill[c] != 0) begin
               found    = 1'b1;
               o.status = ST_DEQUEUED;
               o.cls    = 2'(c);
               o.age    = ring_entry[c][ring_head[c]].age;
               o.gender = ring_entry[c][ring_head[c]].gender;
               o.tag    = ring_entry[c][ring_head[c]].tag;
               ring_head[c] = (ring_head[c] + 1) % CLASS_DEPTH;
               ring_fill[c]--;
            end
         end
      end
      status_tally[o.status]++;
      return o;
   endfunction

   function automatic void add_request(input logic op, input logic [1:0] cls,
                                       input logic [AGE_BITS-1:0] age, input logic gender,
                                       input logic [TAG_BITS-1:0] tag);
      request_type r;
      r.operation = op;
      r.cls       = cls;
      r.age       = age;
      r.gender    = gender;
      r.tag       = tag;
      request_backlog.push_back(r);
   endfunction

   function automatic logic [1:0] random_class();
      if ($urandom_range(99) < 4) return CLS_INVALID;
      return 2'($urandom_range(NUM_CLASSES - 1));
   endfunction

   function automatic void add_enqueue(input logic [1:0] cls);
      add_request(OP_ENQUEUE, cls, AGE_BITS'($urandom_range(127)), 1'($urandom_range(1)),
                  TAG_BITS'($urandom()));
   endfunction

   // dequeue with random content in the fields the block ignores
   function automatic void add_dequeue();
      add_request(OP_DEQUEUE, 2'($urandom_range(3)), AGE_BITS'($urandom_range(127)),
                  1'($urandom_range(1)), TAG_BITS'($urandom()));
   endfunction

   initial begin : stimulus
      segment_kind_type kind;
      int               seg_len;
      int               fill_cls;
      int               total;
      int               i;

      // directed: empty queue, field extremes, invalid class, priority order
      add_request(OP_DEQUEUE, CLS_INVALID, 7'd127, 1'b1, 16'hffff);
      add_request(OP_ENQUEUE, CLS_REGULAR, 7'd0, 1'b0, 16'h0000);
      add_request(OP_ENQUEUE, CLS_POOR, 7'd127, 1'b1, 16'hffff);
      add_request(OP_ENQUEUE, CLS_CRITICAL, 7'd64, 1'b0, 16'h8000);
      add_request(OP_ENQUEUE, CLS_CRITICAL, 7'd1, 1'b1, 16'h0001);
      add_request(OP_ENQUEUE, CLS_INVALID, 7'd99, 1'b1, 16'h1234);
      add_request(OP_ENQUEUE, CLS_POOR, 7'd42, 1'b0, 16'h5555);
      add_request(OP_ENQUEUE, CLS_REGULAR, 7'd85, 1'b1, 16'haaaa);
      add_request(OP_ENQUEUE, CLS_CRITICAL, 7'd127, 1'b1, 16'h7fff);
      repeat (7) add_dequeue();
      add_request(OP_ENQUEUE, CLS_REGULAR, 7'd3, 1'b0, 16'h00ff);
      add_request(OP_DEQUEUE, CLS_CRITICAL, 7'd0, 1'b0, 16'h0000);
      add_request(OP_ENQUEUE, CLS_POOR, 7'd10, 1'b1, 16'hff00);
      add_request(OP_ENQUEUE, CLS_CRITICAL, 7'd20, 1'b0, 16'h0f0f);
      repeat (3) add_dequeue();

      // random segments; fill runs can overflow a class, drain runs can hit empty
      total = request_backlog.size() + RANDOM_ITEMS;
      while (request_backlog.size() < total) begin
         i = $urandom_range(99);
         kind = (i < 15) ? SEG_FILL : (i < 40) ? SEG_DRAIN :
                (i < 65) ? SEG_ENQ_HEAVY : SEG_MIXED;
         case (kind)
            SEG_FILL: begin
               fill_cls = $urandom_range(NUM_CLASSES - 1);
               seg_len  = $urandom_range(CLASS_DEPTH + 8, CLASS_DEPTH - 4);
               repeat (seg_len) begin
                  if ($urandom_range(99) < 90) add_enqueue(2'(fill_cls));
                  else add_enqueue(random_class());
               end
            end
            SEG_DRAIN: begin
               seg_len = $urandom_range(100, 10);
               repeat (seg_len) begin
                  if ($urandom_range(99) < 85) add_dequeue();
                  else add_enqueue(random_class());
               end
            end
            SEG_ENQ_HEAVY: begin
               seg_len = $urandom_range(40, 5);
               repeat (seg_len) begin
                  if ($urandom_range(99) < 75) add_enqueue(random_class());
                  else add_dequeue();
               end
            end
            default: begin
               seg_len = $urandom_range(30, 1);
               repeat (seg_len) begin
                  if ($urandom_range(1) == 0) add_enqueue(random_class());
                  else add_dequeue();
               end
            end
         endcase
      end
      total = request_backlog.size();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (accepted_requests < total) @(negedge clock);
      while (awaited_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Covered %0d requests, %0d results checked: %0d enqueued, %0d dequeued,",
               accepted_requests, checked_results, status_tally[ST_ENQUEUED],
               status_tally[ST_DEQUEUED]);
      $display("%0d dequeues on an empty queue, %0d enqueues rejected (full or invalid class)",
               status_tally[ST_EMPTY], status_tally[ST_FULL]);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // driver: presents the next request at the falling edge
   always @(negedge clock) begin : drive
      request_type item;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (request_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
               item = request_backlog.pop_front();
               req_valid     <= 1'b1;
               req_operation <= item.operation;
               req_in_class  <= item.cls;
               req_in_age    <= item.age;
               req_in_gender <= item.gender;
               req_in_tag    <= item.tag;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // monitor: checks results, predicts accepted requests, runs the watchdog
   always @(posedge clock) begin : observe
      request_type seen;
      outcome_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               report_mismatch($sformatf("result with no request waiting, status %0d",
                                         rsp_status));
            end else begin
               want = awaited_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                            checked_results, rsp_status, want.status));
               if (rsp_out_class !== want.cls)
                  report_mismatch($sformatf("result %0d: class %0d, expected %0d",
                                            checked_results, rsp_out_class, want.cls));
               if (rsp_out_age !== want.age)
                  report_mismatch($sformatf("result %0d: age %0d, expected %0d",
                                            checked_results, rsp_out_age, want.age));
               if (rsp_out_gender !== want.gender)
                  report_mismatch($sformatf("result %0d: gender %0d, expected %0d",
                                            checked_results, rsp_out_gender, want.gender));
               if (rsp_out_tag !== want.tag)
                  report_mismatch($sformatf("result %0d: tag %h, expected %h",
                                            checked_results, rsp_out_tag, want.tag));
            end
            checked_results++;
         end
         if (req_valid && req_ready) begin
            seen.operation = req_operation;
            seen.cls       = req_in_class;
            seen.age       = req_in_age;
            seen.gender    = req_in_gender;
            seen.tag       = req_in_tag;
            awaited_results.push_back(predict_outcome(seen));
            accepted_requests++;
            req_taken = 1'b1;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stalled_cycles = 0;
         end else begin
            stalled_cycles++;
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
               $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                        WATCHDOG_LIMIT, awaited_results.size());
               $display("Testbench completed WITH ERRORS");
               $finish;
            end
         end
      end
   end

endmodule
